>>> sv/mi44_pkg.sv
package mi44_pkg;

  localparam int unsigned ELEM_W        = 32;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;
  // a 3x3 minor of 32-bit elements stays below 6 * 2^93
  localparam int unsigned ADJ_W         = 98;
  // the determinant stays below 24 * 2^124
  localparam int unsigned ACC_W         = 132;
  localparam int unsigned LIMB_W        = 32;
  localparam int unsigned WIDE_W        = 4 * LIMB_W;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned QPTR_W        = $clog2(QDEPTH);

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } elem_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             neg;
  } term_t;

  function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] d);
    return (i >= d) ? i + 2'd1 : i;
  endfunction

  // one of the six triple products of cofactor k: drops row k[1:0] and column k[3:2]
  function automatic term_t term_sel(input logic [IDX_W-1:0] k, input logic [2:0] t);
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] p0;
    logic [1:0] p1;
    logic [1:0] p2;
    logic       psgn;
    term_t      res;
    r = k[3:2];
    c = k[1:0];
    case (t)
      3'd0: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; psgn = 1'b0; end
      3'd1: begin p0 = 2'd1; p1 = 2'd2; p2 = 2'd0; psgn = 1'b0; end
      3'd2: begin p0 = 2'd2; p1 = 2'd0; p2 = 2'd1; psgn = 1'b0; end
      3'd3: begin p0 = 2'd0; p1 = 2'd2; p2 = 2'd1; psgn = 1'b1; end
      3'd4: begin p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; psgn = 1'b1; end
      default: begin p0 = 2'd2; p1 = 2'd1; p2 = 2'd0; psgn = 1'b1; end
    endcase
    res.a   = {skip_idx(2'd0, c), skip_idx(p0, r)};
    res.b   = {skip_idx(2'd1, c), skip_idx(p1, r)};
    res.c   = {skip_idx(2'd2, c), skip_idx(p2, r)};
    res.neg = psgn ^ r[0] ^ c[0];
    return res;
  endfunction

endpackage

>>> sv/mi44_front.sv
module mi44_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,   // [31:0] element_value
  input  logic                         q_ready_i,
  output logic                         q_push_o,
  output mi44_pkg::elem_t              q_data_o
);
  import mi44_pkg::*;

  logic [IDX_W-1:0] count_q;
  logic [IDX_W-1:0] count_d;

  assign s_axis_tready  = q_ready_i;
  assign q_push_o       = s_axis_tvalid && q_ready_i;
  assign q_data_o.value = s_axis_tdata;
  assign q_data_o.idx   = count_q;
  assign q_data_o.last  = (count_q == IDX_W'(15));
  assign count_d        = count_q + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (q_push_o) begin
      count_q <= count_d;
    end
  end

endmodule

>>> sv/mi44_queue.sv
module mi44_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mi44_pkg::elem_t push_data_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mi44_pkg::elem_t pop_data_o
);
  import mi44_pkg::*;

  elem_t             slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QPTR_W:0]   fill_q;
  logic              do_push;
  logic              do_pop;

  assign ready_o    = (fill_q != (QPTR_W+1)'(QDEPTH));
  assign valid_o    = (fill_q != '0);
  assign pop_data_o = slot_q[rptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + QPTR_W'(1);
      if (do_push && !do_pop)      fill_q <= fill_q + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) fill_q <= fill_q - (QPTR_W+1)'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (QPTR_W+1)'(QDEPTH)) else $error("queue fill beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q == rptr_q) |-> (fill_q == '0 || fill_q == (QPTR_W+1)'(QDEPTH)))
    else $error("queue pointers disagree with fill");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> fill_q == $past(fill_q) + (QPTR_W+1)'(1))
    else $error("queue fill not tracking push");

endmodule

>>> sv/mi44_back.sv
module mi44_back #(
  parameter int unsigned FRAC_BITS = mi44_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  mi44_pkg::elem_t q_data_i,
  output logic            q_pop_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [39:0]     m_axis_tdata,   // [31:0] result_value, [35:32] result_index, zeros
  output logic [1:0]      m_axis_tuser,   // [0] is_singular, [1] saturated
  output logic            m_axis_tlast
);
  import mi44_pkg::*;

  localparam int unsigned NUM_W = ADJ_W + 2 * FRAC_BITS;
  localparam int unsigned HI_W  = NUM_W - LIMB_W;
  localparam int unsigned DEN_W = ACC_W;
  localparam int unsigned CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  typedef enum logic [3:0] {
    S_LOAD, S_TRD, S_TAB, S_MAC, S_DRAIN, S_TNEXT, S_DRD, S_DW, S_DNEXT,
    S_QRD, S_QSET, S_DIV, S_SRD, S_OUT
  } state_e;

  state_e state_q;

  // memories
  logic [ELEM_W-1:0]       store_mem [16];
  logic [ADJ_W-1:0]        adj_mem [16];
  logic [ELEM_W-1:0]       rd0_q;
  logic [ELEM_W-1:0]       rd1_q;
  logic signed [ADJ_W-1:0] adj_rd_q;
  logic                    re0;
  logic                    re1;
  logic [IDX_W-1:0]        ra0;
  logic [IDX_W-1:0]        ra1;
  logic                    adj_re;
  logic [IDX_W-1:0]        adj_ra;
  logic                    adj_we;
  logic                    st_we;

  // sequencing
  logic [IDX_W-1:0] k_q;
  logic [2:0]       t_q;
  logic [1:0]       dcnt_q;
  logic             det_ph_q;
  logic [1:0]       j_q;
  logic [1:0]       lim_last_q;
  logic [4:0]       bcnt_q;
  term_t            term;

  // multiply-accumulate
  logic [WIDE_W-1:0]       w_q;
  logic [LIMB_W-1:0]       limb;
  logic signed [LIMB_W:0]  limb_s;
  logic signed [64:0]      mprod_d;
  logic signed [64:0]      mprod_q;
  logic signed [63:0]      abprod;
  logic [1:0]              msh_q;
  logic                    mval_q;
  logic                    mneg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] acc_d;

  // division
  logic [DEN_W-1:0]  detmag_q;
  logic              det_neg_q;
  logic              sing_q;
  logic [DEN_W-1:0]  det_mag_d;
  logic [ADJ_W-1:0]  adj_mag;
  logic [NUM_W-1:0]  num;
  logic [HI_W-1:0]   num_hi;
  logic              hsat_d;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W:0]    rem2;
  logic [DEN_W:0]    rem_sub;
  logic              rem_geq;
  logic [31:0]       lo_q;
  logic [31:0]       quo_q;
  logic              hsat_q;
  logic              qneg_q;

  // result
  logic [31:0] res_val;
  logic        res_sat;
  logic        ovalid_q;
  logic [31:0] oval_q;
  logic [3:0]  oidx_q;
  logic        osing_q;
  logic        osat_q;
  logic        olast_q;
  logic        out_free;

  assign term    = term_sel(k_q, t_q);
  assign q_pop_o = (state_q == S_LOAD) && q_valid_i;
  assign st_we   = q_pop_o;

  always_comb begin
    re0    = 1'b0;
    re1    = 1'b0;
    ra0    = term.a;
    ra1    = term.b;
    adj_re = 1'b0;
    adj_ra = k_q;
    adj_we = 1'b0;
    case (state_q)
      S_TRD: begin
        re0 = 1'b1;
        re1 = 1'b1;
      end
      S_TAB: begin
        re0 = 1'b1;
        ra0 = term.c;
      end
      S_DRD: begin
        re0    = 1'b1;
        ra0    = {2'b00, dcnt_q};
        adj_re = 1'b1;
        adj_ra = {dcnt_q, 2'b00};
      end
      S_QRD: adj_re = 1'b1;
      S_SRD: begin
        re0 = 1'b1;
        ra0 = k_q;
      end
      S_TNEXT: adj_we = (t_q == 3'd5);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we)  store_mem[q_data_i.idx] <= q_data_i.value;
    if (re0)    rd0_q <= store_mem[ra0];
    if (re1)    rd1_q <= store_mem[ra1];
    if (adj_we) adj_mem[k_q] <= acc_q[ADJ_W-1:0];
    if (adj_re) adj_rd_q <= adj_mem[adj_ra];
  end

  // one 32-bit limb of the wide operand per cycle, the top limb signed
  assign limb    = w_q[{j_q, 5'd0} +: LIMB_W];
  assign limb_s  = {(j_q == lim_last_q) & limb[LIMB_W-1], limb};
  assign mprod_d = $signed(rd0_q) * limb_s;
  assign abprod  = $signed(rd0_q) * $signed(rd1_q);
  assign addend  = ACC_W'(mprod_q) <<< {msh_q, 5'd0};
  assign acc_d   = mneg_q ? acc_q - addend : acc_q + addend;

  assign det_mag_d = acc_q[ACC_W-1] ? DEN_W'(-acc_q) : DEN_W'(acc_q);
  assign adj_mag   = adj_rd_q[ADJ_W-1] ? ADJ_W'(-adj_rd_q) : ADJ_W'(adj_rd_q);
  assign num       = NUM_W'(adj_mag) << (2 * FRAC_BITS);
  assign num_hi    = num[NUM_W-1:LIMB_W];
  assign hsat_d    = CMP_W'(num_hi) >= CMP_W'(detmag_q);
  assign rem2      = {rem_q, lo_q[31]};
  assign rem_geq   = rem2 >= {1'b0, detmag_q};
  assign rem_sub   = rem2 - {1'b0, detmag_q};

  always_comb begin
    res_val = quo_q;
    res_sat = 1'b0;
    if (sing_q) begin
      res_val = rd0_q;
    end else if (qneg_q) begin
      if (hsat_q || quo_q > 32'h8000_0000) begin
        res_val = 32'h8000_0000;
        res_sat = 1'b1;
      end else begin
        res_val = 32'd0 - quo_q;
      end
    end else if (hsat_q || quo_q[31]) begin
      res_val = 32'h7FFF_FFFF;
      res_sat = 1'b1;
    end
  end

  assign out_free = !ovalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      k_q        <= '0;
      t_q        <= '0;
      dcnt_q     <= '0;
      det_ph_q   <= 1'b0;
      j_q        <= '0;
      lim_last_q <= '0;
      bcnt_q     <= '0;
      w_q        <= '0;
      mprod_q    <= '0;
      msh_q      <= '0;
      mval_q     <= 1'b0;
      mneg_q     <= 1'b0;
      acc_q      <= '0;
      detmag_q   <= '0;
      det_neg_q  <= 1'b0;
      sing_q     <= 1'b0;
      rem_q      <= '0;
      lo_q       <= '0;
      quo_q      <= '0;
      hsat_q     <= 1'b0;
      qneg_q     <= 1'b0;
      ovalid_q   <= 1'b0;
      oval_q     <= '0;
      oidx_q     <= '0;
      osing_q    <= 1'b0;
      osat_q     <= 1'b0;
      olast_q    <= 1'b0;
    end else begin
      mval_q <= 1'b0;
      if (mval_q) acc_q <= acc_d;
      // in S_OUT a taken beat is replaced by the next one below
      if (ovalid_q && m_axis_tready && (state_q != S_OUT)) ovalid_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (q_valid_i && q_data_i.last) begin
            k_q      <= '0;
            t_q      <= '0;
            det_ph_q <= 1'b0;
            acc_q    <= '0;
            state_q  <= S_TRD;
          end
        end
        S_TRD: state_q <= S_TAB;
        S_TAB: begin
          w_q        <= WIDE_W'(abprod);
          mneg_q     <= term.neg;
          lim_last_q <= 2'd1;
          j_q        <= '0;
          state_q    <= S_MAC;
        end
        S_MAC: begin
          mprod_q <= mprod_d;
          msh_q   <= j_q;
          mval_q  <= 1'b1;
          if (j_q == lim_last_q) state_q <= S_DRAIN;
          else j_q <= j_q + 2'd1;
        end
        S_DRAIN: state_q <= det_ph_q ? S_DNEXT : S_TNEXT;
        S_TNEXT: begin
          if (t_q != 3'd5) begin
            t_q     <= t_q + 3'd1;
            state_q <= S_TRD;
          end else begin
            t_q   <= '0;
            acc_q <= '0;
            if (k_q == IDX_W'(15)) begin
              det_ph_q <= 1'b1;
              dcnt_q   <= '0;
              state_q  <= S_DRD;
            end else begin
              k_q     <= k_q + IDX_W'(1);
              state_q <= S_TRD;
            end
          end
        end
        S_DRD: state_q <= S_DW;
        S_DW: begin
          w_q        <= WIDE_W'(adj_rd_q);
          mneg_q     <= 1'b0;
          lim_last_q <= 2'd3;
          j_q        <= '0;
          state_q    <= S_MAC;
        end
        S_DNEXT: begin
          if (dcnt_q != 2'd3) begin
            dcnt_q  <= dcnt_q + 2'd1;
            state_q <= S_DRD;
          end else begin
            detmag_q  <= det_mag_d;
            det_neg_q <= acc_q[ACC_W-1];
            sing_q    <= (acc_q == '0);
            k_q       <= '0;
            state_q   <= (acc_q == '0) ? S_SRD : S_QRD;
          end
        end
        S_QRD: state_q <= S_QSET;
        S_QSET: begin
          hsat_q <= hsat_d;
          qneg_q <= adj_rd_q[ADJ_W-1] ^ det_neg_q;
          rem_q  <= DEN_W'(num_hi);
          lo_q   <= num[LIMB_W-1:0];
          quo_q  <= '0;
          bcnt_q <= '0;
          state_q <= hsat_d ? S_OUT : S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          lo_q  <= {lo_q[30:0], 1'b0};
          quo_q <= {quo_q[30:0], rem_geq};
          rem_q <= rem_geq ? DEN_W'(rem_sub) : DEN_W'(rem2);
          bcnt_q <= bcnt_q + 5'd1;
          if (bcnt_q == 5'd31) state_q <= S_OUT;
        end
        S_SRD: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            oval_q   <= res_val;
            oidx_q   <= k_q;
            osing_q  <= sing_q;
            osat_q   <= res_sat;
            olast_q  <= (k_q == IDX_W'(15));
            k_q      <= k_q + IDX_W'(1);
            if (k_q == IDX_W'(15)) state_q <= S_LOAD;
            else state_q <= sing_q ? S_SRD : S_QRD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'd0, oidx_q, oval_q};
  assign m_axis_tuser  = {osat_q, osing_q};
  assign m_axis_tlast  = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && olast_q) |-> (oidx_q == 4'd15)) else $error("last beat not at index 15");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && osing_q) |-> !osat_q) else $error("singular beat marked saturated");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < detmag_q)) else $error("division remainder out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !ovalid_q || (state_q == S_LOAD)) else $error("pop outside load");

endmodule

>>> sv/matrix_inverse_4x4.sv
// matrix rate: set by the shared multiply-accumulate unit and the 1-bit-per-cycle divider
// singular matrix: results follow after the determinant, with no division
// reset: asynchronous active low, clears load count, queue, sequencer and output valid
module matrix_inverse_4x4 #(
  parameter int unsigned FRAC_BITS = mi44_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] element_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] result_value, [35:32] result_index, zeros
  output logic [1:0]  m_axis_tuser,   // [0] is_singular, [1] saturated
  output logic        m_axis_tlast
);
  import mi44_pkg::*;

  logic  q_push;
  logic  q_ready;
  logic  q_valid;
  logic  q_pop;
  elem_t q_in;
  elem_t q_out;

  mi44_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  mi44_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  mi44_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_out),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
